// ===== hw/rtl/jfss_pkg.sv =====
// Shared types, codes and helpers for the JPEG frame size scanner.
package jfss_pkg;

    // Scan phase codes
    localparam logic [3:0] PH_SOI0 = 4'd0;
    localparam logic [3:0] PH_SOI1 = 4'd1;
    localparam logic [3:0] PH_MK0  = 4'd2;
    localparam logic [3:0] PH_MK1  = 4'd3;
    localparam logic [3:0] PH_LEN0 = 4'd4;
    localparam logic [3:0] PH_LEN1 = 4'd5;
    localparam logic [3:0] PH_SKIP = 4'd6;
    localparam logic [3:0] PH_PREC = 4'd7;
    localparam logic [3:0] PH_H0   = 4'd8;
    localparam logic [3:0] PH_H1   = 4'd9;
    localparam logic [3:0] PH_W0   = 4'd10;
    localparam logic [3:0] PH_W1   = 4'd11;

    // Result status codes
    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_NOSOI  = 2'd1;
    localparam logic [1:0] ST_NOSOF  = 2'd2;
    localparam logic [1:0] ST_BADLEN = 2'd3;

    // Marker byte values
    localparam logic [7:0] BYTE_MARK  = 8'hff;
    localparam logic [7:0] BYTE_SOI   = 8'hd8;
    localparam logic [7:0] SOF_MASK   = 8'hf0;
    localparam logic [7:0] SOF_BASE   = 8'hc0;
    localparam logic [7:0] CODE_DHT   = 8'hc4;
    localparam logic [7:0] CODE_JPG   = 8'hc8;
    localparam logic [7:0] CODE_DAC   = 8'hcc;
    localparam logic [15:0] LEN_FIELD = 16'd2;

    typedef struct packed {
        logic [3:0]  phase;
        logic [15:0] skip_remaining;
        logic [7:0]  length_high_byte;
        logic        marker_is_frame;
        logic [15:0] height_held;
        logic [7:0]  width_high_byte;
        logic        result_given;
    } scan_state_t;

    typedef struct packed {
        logic [15:0] image_height;
        logic [15:0] image_width;
        logic [1:0]  status;
    } scan_result_t;

    localparam scan_state_t STATE_RESET = '{phase: PH_SOI0, default: '0};

    // True for a start-of-frame code: C0..CF without DHT, JPG and DAC
    function automatic logic frame_code(input logic [7:0] b);
        logic hit;
        hit = ((b & SOF_MASK) == SOF_BASE) && (b != CODE_DHT) && (b != CODE_JPG)
            && (b != CODE_DAC);
        return hit;
    endfunction

endpackage

// ===== hw/rtl/jfss_step.sv =====
// Next-state and result logic for one byte of the scanner.
module jfss_step
(
    input  jfss_pkg::scan_state_t  state,
    input  logic [7:0]             data_byte,
    input  logic                   is_last,
    output jfss_pkg::scan_state_t  state_next,
    output logic                   emit,
    output jfss_pkg::scan_result_t result
);

    logic [15:0] seg_len;
    logic [15:0] skip_dec;

    assign seg_len  = {state.length_high_byte, data_byte};
    assign skip_dec = (state.skip_remaining != 16'd0) ? state.skip_remaining - 16'd1
                                                      : state.skip_remaining;

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        result     = '{image_height: 16'd0, image_width: 16'd0,
                       status: jfss_pkg::ST_FOUND};

        // Advance the marker walk while no result has gone out
        if (!state.result_given)
        begin
            unique case (state.phase)
                jfss_pkg::PH_SOI0:
                begin
                    if (data_byte == jfss_pkg::BYTE_MARK)
                        state_next.phase = jfss_pkg::PH_SOI1;
                    else
                    begin
                        emit          = 1'b1;
                        result.status = jfss_pkg::ST_NOSOI;
                    end
                end
                jfss_pkg::PH_SOI1:
                begin
                    if (data_byte == jfss_pkg::BYTE_SOI)
                        state_next.phase = jfss_pkg::PH_MK0;
                    else
                    begin
                        emit          = 1'b1;
                        result.status = jfss_pkg::ST_NOSOI;
                    end
                end
                jfss_pkg::PH_MK0:
                begin
                    state_next.marker_is_frame = (data_byte == jfss_pkg::BYTE_MARK);
                    state_next.phase           = jfss_pkg::PH_MK1;
                end
                jfss_pkg::PH_MK1:
                begin
                    state_next.marker_is_frame = state.marker_is_frame
                                               && jfss_pkg::frame_code(data_byte);
                    state_next.phase           = jfss_pkg::PH_LEN0;
                end
                jfss_pkg::PH_LEN0:
                begin
                    state_next.length_high_byte = data_byte;
                    state_next.phase            = jfss_pkg::PH_LEN1;
                end
                jfss_pkg::PH_LEN1:
                begin
                    if (state.marker_is_frame)
                        state_next.phase = jfss_pkg::PH_PREC;
                    else if (seg_len < jfss_pkg::LEN_FIELD)
                    begin
                        emit          = 1'b1;
                        result.status = jfss_pkg::ST_BADLEN;
                    end
                    else if (seg_len == jfss_pkg::LEN_FIELD)
                        state_next.phase = jfss_pkg::PH_MK0;
                    else
                    begin
                        state_next.skip_remaining = seg_len - jfss_pkg::LEN_FIELD;
                        state_next.phase          = jfss_pkg::PH_SKIP;
                    end
                end
                jfss_pkg::PH_SKIP:
                begin
                    state_next.skip_remaining = skip_dec;
                    if (skip_dec == 16'd0)
                        state_next.phase = jfss_pkg::PH_MK0;
                end
                jfss_pkg::PH_PREC:
                    state_next.phase = jfss_pkg::PH_H0;
                jfss_pkg::PH_H0:
                begin
                    state_next.height_held = {data_byte, 8'd0};
                    state_next.phase       = jfss_pkg::PH_H1;
                end
                jfss_pkg::PH_H1:
                begin
                    state_next.height_held = {state.height_held[15:8], data_byte};
                    state_next.phase       = jfss_pkg::PH_W0;
                end
                jfss_pkg::PH_W0:
                begin
                    state_next.width_high_byte = data_byte;
                    state_next.phase           = jfss_pkg::PH_W1;
                end
                jfss_pkg::PH_W1:
                begin
                    emit                = 1'b1;
                    result.image_height = state.height_held;
                    result.image_width  = {state.width_high_byte, data_byte};
                    result.status       = jfss_pkg::ST_FOUND;
                end
                default:
                    state_next.phase = jfss_pkg::PH_SOI0;
            endcase

            if (emit)
                state_next.result_given = 1'b1;
        end

        // Close the file on the last byte and rearm; judge by the phase this byte reached
        if (is_last)
        begin
            if (!state.result_given && !emit)
            begin
                emit = 1'b1;
                if (state_next.phase == jfss_pkg::PH_SOI0
                    || state_next.phase == jfss_pkg::PH_SOI1)
                    result.status = jfss_pkg::ST_NOSOI;
                else
                    result.status = jfss_pkg::ST_NOSOF;
            end
            state_next = jfss_pkg::STATE_RESET;
        end
    end

endmodule

// ===== hw/rtl/jpeg_frame_size_scanner.sv =====
// Top level of the JPEG frame size scanner: input register, scan state, result register.
// Takes one file byte per item, one item per clock, and gives one result item per file
// (frame height and width, or a status saying why none was found). A byte is held in the
// input register until it is processed, and a result it completes is loaded into the
// output register when that byte is processed, so out_valid rises only after the item
// that completes the result has passed both registers. The input side keeps taking
// one item every cycle as long as the output register is free or being emptied; the only
// stall comes from a held result item that the output side has not taken.
module jpeg_frame_size_scanner
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] image_height,
    output logic [15:0] image_width,
    output logic [1:0]  status
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    jfss_pkg::scan_state_t  state_reg;
    jfss_pkg::scan_state_t  state_next;
    jfss_pkg::scan_result_t res_reg;
    jfss_pkg::scan_result_t step_res;
    logic                   step_emit;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   advance;
    logic                   process;

    // Move the held byte on when the result register can take a result
    assign advance  = !out_valid_reg || out_ready;
    assign process  = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    jfss_step u_step
    (
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .is_last    (in_last_reg),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_res)
    );

    // Work out the valid flags of both registers
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (process)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg && !out_ready;
        if (process && step_emit)
            out_valid_next = 1'b1;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= jfss_pkg::STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process)
                state_reg <= state_next;
        end
    end

    // Capture the incoming item and the outgoing result
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= is_last;
        end
        if (process && step_emit)
            res_reg <= step_res;
    end

    assign out_valid    = out_valid_reg;
    assign image_height = res_reg.image_height;
    assign image_width  = res_reg.image_width;
    assign status       = res_reg.status;

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for the JPEG frame size scanner: directed files, then random byte streams.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]             data;
        logic                   last;
        logic                   typed;
        jfss_pkg::scan_result_t want;
    } stim_row_t;

    localparam int unsigned RANDOM_BYTES = 1400;
    localparam int unsigned HOLD_AT      = 20;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_FILE   = 15;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [1:0]  status;

    // Scanner state as the bench tracks it
    logic [3:0]  sc_phase;
    logic [15:0] sc_skip;
    logic [7:0]  sc_len_hi;
    logic        sc_is_frame;
    logic [15:0] sc_height;
    logic [7:0]  sc_width_hi;
    logic        sc_done;

    jfss_pkg::scan_result_t due_results[$];
    stim_row_t              sample_rows[$];
    logic [7:0]             file_bytes[$];

    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_seen = 0;
    int unsigned files_sent = 0;
    int unsigned tx_calm = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};

    jpeg_frame_size_scanner uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .image_height (image_height),
        .image_width  (image_width),
        .status       (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic scanner_clear();
        sc_phase    = jfss_pkg::PH_SOI0;
        sc_skip     = 16'd0;
        sc_len_hi   = 8'd0;
        sc_is_frame = 1'b0;
        sc_height   = 16'd0;
        sc_width_hi = 8'd0;
        sc_done     = 1'b0;
    endtask

    // Advance the tracked scanner by one byte; give the result it completes, if any
    task automatic advance_scanner(input logic [7:0] b, input logic last,
                                   output logic made, output jfss_pkg::scan_result_t res);
        logic [15:0] seg_len;
        made = 1'b0;
        res = '0;
        seg_len = {sc_len_hi, b};
        if (!sc_done)
        begin
            case (sc_phase)
                jfss_pkg::PH_SOI0:
                begin
                    if (b == jfss_pkg::BYTE_MARK)
                        sc_phase = jfss_pkg::PH_SOI1;
                    else
                    begin
                        made = 1'b1;
                        res.status = jfss_pkg::ST_NOSOI;
                    end
                end
                jfss_pkg::PH_SOI1:
                begin
                    if (b == jfss_pkg::BYTE_SOI)
                        sc_phase = jfss_pkg::PH_MK0;
                    else
                    begin
                        made = 1'b1;
                        res.status = jfss_pkg::ST_NOSOI;
                    end
                end
                jfss_pkg::PH_MK0:
                begin
                    sc_is_frame = (b == jfss_pkg::BYTE_MARK);
                    sc_phase = jfss_pkg::PH_MK1;
                end
                jfss_pkg::PH_MK1:
                begin
                    // start-of-frame is C0..CF, less the DHT, JPG and DAC codes
                    sc_is_frame = sc_is_frame && (b[7:4] == jfss_pkg::SOF_BASE[7:4])
                        && (b != jfss_pkg::CODE_DHT) && (b != jfss_pkg::CODE_JPG)
                        && (b != jfss_pkg::CODE_DAC);
                    sc_phase = jfss_pkg::PH_LEN0;
                end
                jfss_pkg::PH_LEN0:
                begin
                    sc_len_hi = b;
                    sc_phase = jfss_pkg::PH_LEN1;
                end
                jfss_pkg::PH_LEN1:
                begin
                    if (sc_is_frame)
                        sc_phase = jfss_pkg::PH_PREC;
                    else if (seg_len < jfss_pkg::LEN_FIELD)
                    begin
                        made = 1'b1;
                        res.status = jfss_pkg::ST_BADLEN;
                    end
                    else if (seg_len == jfss_pkg::LEN_FIELD)
                        sc_phase = jfss_pkg::PH_MK0;
                    else
                    begin
                        sc_skip = seg_len - jfss_pkg::LEN_FIELD;
                        sc_phase = jfss_pkg::PH_SKIP;
                    end
                end
                jfss_pkg::PH_SKIP:
                begin
                    if (sc_skip != 16'd0)
                        sc_skip = sc_skip - 16'd1;
                    if (sc_skip == 16'd0)
                        sc_phase = jfss_pkg::PH_MK0;
                end
                jfss_pkg::PH_PREC:
                    sc_phase = jfss_pkg::PH_H0;
                jfss_pkg::PH_H0:
                begin
                    sc_height = {b, 8'h00};
                    sc_phase = jfss_pkg::PH_H1;
                end
                jfss_pkg::PH_H1:
                begin
                    sc_height = {sc_height[15:8], b};
                    sc_phase = jfss_pkg::PH_W0;
                end
                jfss_pkg::PH_W0:
                begin
                    sc_width_hi = b;
                    sc_phase = jfss_pkg::PH_W1;
                end
                jfss_pkg::PH_W1:
                begin
                    made = 1'b1;
                    res.image_height = sc_height;
                    res.image_width  = {sc_width_hi, b};
                    res.status       = jfss_pkg::ST_FOUND;
                end
                default:
                    sc_phase = jfss_pkg::PH_SOI0;
            endcase
            if (made)
                sc_done = 1'b1;
        end
        // Last byte closes the file: report why nothing was found, then rearm
        if (last)
        begin
            if (!sc_done)
            begin
                made = 1'b1;
                res = '0;
                res.status = (sc_phase == jfss_pkg::PH_SOI0 || sc_phase == jfss_pkg::PH_SOI1)
                           ? jfss_pkg::ST_NOSOI : jfss_pkg::ST_NOSOF;
            end
            scanner_clear();
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic l = 1'b0,
                           input logic typed = 1'b0,
                           input logic [1:0] st = jfss_pkg::ST_FOUND,
                           input logic [15:0] h = 16'd0, input logic [15:0] w = 16'd0);
        stim_row_t row;
        row.data = b;
        row.last = l;
        row.typed = typed;
        row.want.image_height = h;
        row.want.image_width = w;
        row.want.status = st;
        sample_rows.push_back(row);
    endtask

    // Offer one item after a drawn gap, hold it until taken, then predict
    task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                             input jfss_pkg::scan_result_t want);
        int unsigned gap;
        logic made;
        jfss_pkg::scan_result_t res;
        if (tx_calm > 0)
        begin
            gap = 0;
            tx_calm--;
        end
        else
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        is_last   <= l;
        do @(posedge clk); while (!in_ready);
        advance_scanner(b, l, made, res);
        if (typed)
            due_results.push_back(want);
        else if (made)
            due_results.push_back(res);
        bytes_sent++;
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hffff;
        return 16'($urandom_range(0, 16'hffff));
    endfunction

    // Build one file: mostly well formed with random content, some broken, some noise
    task automatic build_file();
        int unsigned kind;
        int unsigned n_seg;
        int unsigned seg_len;
        int unsigned r;
        int unsigned cut;
        logic [3:0]  lo;
        logic [15:0] h;
        logic [15:0] w;
        file_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            file_bytes.push_back(jfss_pkg::BYTE_MARK);
            file_bytes.push_back(jfss_pkg::BYTE_SOI);
            n_seg = $urandom_range(0, 3);
            repeat (n_seg)
            begin
                file_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                                 : jfss_pkg::BYTE_MARK);
                r = $urandom_range(0, 3);
                if (r == 0)
                    file_bytes.push_back($urandom_range(0, 1) ? jfss_pkg::CODE_DHT
                                         : ($urandom_range(0, 1) ? jfss_pkg::CODE_JPG
                                                                 : jfss_pkg::CODE_DAC));
                else if (r == 1)
                    file_bytes.push_back({jfss_pkg::SOF_BASE[7:4], 4'($urandom)});
                else
                    file_bytes.push_back(8'($urandom));
                r = $urandom_range(0, 19);
                if (r == 0)
                    seg_len = $urandom_range(0, 1);
                else if (r == 1)
                    seg_len = $urandom_range(64, 300);
                else
                    seg_len = $urandom_range(2, 9);
                file_bytes.push_back(seg_len[15:8]);
                file_bytes.push_back(seg_len[7:0]);
                if (seg_len > 2)
                    repeat (seg_len - 2) file_bytes.push_back(8'($urandom));
            end
            // frame header with a frame code
            do lo = 4'($urandom); while (lo == 4'h4 || lo == 4'h8 || lo == 4'hc);
            h = pick_dim();
            w = pick_dim();
            file_bytes.push_back(jfss_pkg::BYTE_MARK);
            file_bytes.push_back({jfss_pkg::SOF_BASE[7:4], lo});
            file_bytes.push_back(8'($urandom));
            file_bytes.push_back(8'($urandom));
            file_bytes.push_back(8'($urandom));
            file_bytes.push_back(h[15:8]);
            file_bytes.push_back(h[7:0]);
            file_bytes.push_back(w[15:8]);
            file_bytes.push_back(w[7:0]);
            repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 6) == 0)
            begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
        end
        else if (kind < 85)
        begin
            if ($urandom_range(0, 1))
                file_bytes.push_back(jfss_pkg::BYTE_MARK);
            file_bytes.push_back(8'($urandom));
            repeat ($urandom_range(0, 8)) file_bytes.push_back(8'($urandom));
        end
        else
            repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom));
    endtask

    // Take result items with drawn stalls, one long hold-off, and check each
    initial
    begin : result_side
        int unsigned stall;
        int unsigned rx_calm;
        jfss_pkg::scan_result_t want;
        rx_calm = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_calm > 0)
            begin
                stall = 0;
                rx_calm--;
            end
            else
            begin
                stall = $urandom_range(0, 12);
                if ($urandom_range(0, 15) == 0)
                    rx_calm = 20;
            end
            if (results_seen == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results_seen++;
            status_seen[status]++;
            if (due_results.size() == 0)
                report_mismatch("unexpected result status", status, 0);
            else
            begin
                want = due_results.pop_front();
                if (image_height !== want.image_height)
                    report_mismatch("image_height", image_height, want.image_height);
                if (image_width !== want.image_width)
                    report_mismatch("image_width", image_width, want.image_width);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
            end
        end
    end

    initial
    begin : stimulus
        int unsigned directed_bytes;
        jfss_pkg::scan_result_t none;
        none = '0;
        scanner_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Marker with FF missing, length two on DHT, frame header with zero length,
        // largest height and zero width, completed by the last byte
        add_row(8'hff); add_row(8'hd8);
        add_row(8'h12); add_row(8'h34); add_row(8'h00); add_row(8'h03); add_row(8'h55);
        add_row(8'hff); add_row(jfss_pkg::CODE_DHT); add_row(8'h00); add_row(8'h02);
        add_row(8'hff); add_row(8'hcf); add_row(8'h00); add_row(8'h00); add_row(8'h08);
        add_row(8'hff); add_row(8'hff); add_row(8'h00);
        add_row(8'h00, 1'b1, 1'b1, jfss_pkg::ST_FOUND, 16'hffff, 16'h0000);
        // Bad first byte on the last byte itself
        add_row(8'h00, 1'b1, 1'b1, jfss_pkg::ST_NOSOI);
        // Bad second byte, then a trailing byte that only rearms
        add_row(8'hff); add_row(8'h17, 1'b0, 1'b1, jfss_pkg::ST_NOSOI); add_row(8'h5a, 1'b1);
        // Segment length of zero
        add_row(8'hff); add_row(8'hd8); add_row(8'hff); add_row(8'hdb); add_row(8'h00);
        add_row(8'h00, 1'b1, 1'b1, jfss_pkg::ST_BADLEN);
        // File ends straight after start-of-image
        add_row(8'hff); add_row(8'hd8, 1'b1, 1'b1, jfss_pkg::ST_NOSOF);

        foreach (sample_rows[i])
            send_byte(sample_rows[i].data, sample_rows[i].last, sample_rows[i].typed,
                      sample_rows[i].want);
        directed_bytes = bytes_sent;
        wait_drained();

        // Random files until the byte budget is spent
        while (bytes_sent < directed_bytes + RANDOM_BYTES)
        begin
            build_file();
            if ($urandom_range(0, 3) == 0)
                tx_calm = file_bytes.size();
            foreach (file_bytes[i])
                send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, none);
            files_sent++;
            if (files_sent == DRAIN_FILE)
                wait_drained();
        end
        wait_drained();
        repeat (12) @(posedge clk);

        $display("covered %0d bytes: %0d directed, %0d random files; %0d results taken",
                 bytes_sent, directed_bytes, files_sent, results_seen);
        $display("status mix: %0d found, %0d no start-of-image, %0d no frame header, %0d bad length",
                 status_seen[jfss_pkg::ST_FOUND], status_seen[jfss_pkg::ST_NOSOI],
                 status_seen[jfss_pkg::ST_NOSOF], status_seen[jfss_pkg::ST_BADLEN]);
        if (mismatches == 0)
            $display("jpeg_frame_size_scanner regression: pass");
        else
            $display("jpeg_frame_size_scanner regression: fail");
        $finish;
    end

    // Stop a hung run
    initial
    begin : watchdog
        #5_000_000;
        $display("timeout with %0d results outstanding", due_results.size());
        $display("jpeg_frame_size_scanner regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/jfss_pkg.sv
hw/rtl/jfss_step.sv
hw/rtl/jpeg_frame_size_scanner.sv
dv/tb.sv
